// File: sv/grub_pkg.sv
package grub_pkg;

	typedef enum logic [2:0] {
		OP_ACTIVATE   = 3'd0,
		OP_COMPLETE   = 3'd1,
		OP_NONCONTEND = 3'd2,
		OP_DETACH     = 3'd3,
		OP_ADVANCE    = 3'd4,
		OP_BUDGET     = 3'd5
	} op_t;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [20:0] SUM_MAX = 21'h1FFFFF;
	localparam logic [16:0] BW_MAX  = 17'h1FFFF;
	localparam logic [47:0] T48_MAX = 48'hFFFFFFFFFFFF;
	localparam logic [31:0] B32_MAX = 32'hFFFFFFFF;

	localparam logic [0:0] REG_PROC_COUNT = 1'd0;
	localparam logic [0:0] REG_MIN_BW     = 1'd1;

	// Request to the shared serial divider.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [32:0] remainder;
	} div_rsp_t;

endpackage

// File: sv/grub_bandwidth_reclaim_unit_core.sv
// Sequence: input transfer, table update, utilization memory scan, bandwidth
// divide, then up to one query divide for advance or two for budget (none when
// no budget is due, one when the first quotient saturates), then result valid.
// Throughput: one event in flight; the next input is taken the cycle after the
// result transfer. The serial divider serves the bandwidth and query divides.
// Reset: asynchronous, clears flags, sums, registers (m=1, floor=655).
module grub_bandwidth_reclaim_unit_core #(
	parameter int MAX_SERVERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [3:0]  server_index,
	input  logic [16:0] utilization,
	input  logic [31:0] exec_ticks,
	input  logic [47:0] now_time,
	input  logic [47:0] server_vtime,
	input  logic [47:0] deadline,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] new_virtual_time,
	output logic [31:0] budget,
	output logic        go_non_contending,
	output logic [16:0] bandwidth,
	output logic [20:0] active_utilization
);

	logic [4:0]  proc_count_q;
	logic [16:0] min_bw_q;
	grub_pkg::div_req_t dreq;
	grub_pkg::div_rsp_t drsp;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_count_q <= 5'd1;
			min_bw_q     <= 17'd655;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == grub_pkg::REG_PROC_COUNT)
				proc_count_q <= pwdata[4:0];
			else
				min_bw_q <= pwdata[16:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == grub_pkg::REG_PROC_COUNT)
			prdata = {27'd0, proc_count_q};
		else
			prdata = {15'd0, min_bw_q};
	end

	grub_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	grub_core_ctl #(.MAX_SERVERS(MAX_SERVERS)) u_ctl (
		.clk                (clk),
		.arst_n             (arst_n),
		.proc_count         (proc_count_q),
		.min_bw             (min_bw_q),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.opcode             (opcode),
		.server_index       (server_index),
		.utilization        (utilization),
		.exec_ticks         (exec_ticks),
		.now_time           (now_time),
		.server_vtime       (server_vtime),
		.deadline           (deadline),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.new_virtual_time   (new_virtual_time),
		.budget             (budget),
		.go_non_contending  (go_non_contending),
		.bandwidth          (bandwidth),
		.active_utilization (active_utilization),
		.dreq               (dreq),
		.drsp               (drsp)
	);

endmodule

// File: sv/grub_div.sv
// Restoring divider, one quotient bit per cycle.
module grub_div (
	input  logic                clk,
	input  logic                arst_n,
	input  grub_pkg::div_req_t  req,
	output grub_pkg::div_rsp_t  rsp
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: sv/grub_core_ctl.sv
// Sequencer: table update in memory, max scan, bw divide, query math.
module grub_core_ctl #(
	parameter int MAX_SERVERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          proc_count,
	input  logic [16:0]         min_bw,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic [3:0]          server_index,
	input  logic [16:0]         utilization,
	input  logic [31:0]         exec_ticks,
	input  logic [47:0]         now_time,
	input  logic [47:0]         server_vtime,
	input  logic [47:0]         deadline,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [47:0]         new_virtual_time,
	output logic [31:0]         budget,
	output logic                go_non_contending,
	output logic [16:0]         bandwidth,
	output logic [20:0]         active_utilization,
	output grub_pkg::div_req_t  dreq,
	input  grub_pkg::div_rsp_t  drsp
);

	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_UPD, S_SCAN, S_SCAN_LAST, S_BWDIV, S_BWWAIT, S_BWFIN,
		S_ADV, S_ADVWAIT, S_BUDQ, S_BUDQWAIT, S_BUDR, S_BUDRWAIT, S_FIN
	} state_t;

	state_t state_q;

	// Utilization store with one valid flag per entry.
	logic [16:0] util_mem [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] flag_q;
	logic [16:0] rd_data_s1;
	logic        rd_flag_s1;
	logic [IW-1:0] scan_idx_q;

	logic [2:0]  op_q;
	logic [16:0] u_q;
	logic [31:0] exec_q;
	logic [47:0] now_q, vt_q, dl_q;
	logic        in_tab_q;
	logic [IW-1:0] idx_q;
	logic [20:0] sched_q, active_q;
	logic [16:0] umax_q;
	logic        any_q;
	logic [16:0] bw_q;
	logic [31:0] q_q;
	logic [47:0] nvt_q;
	logic [31:0] bud_q;
	logic        go_q;
	logic        out_v_q;

	logic [4:0]  m_eff;
	logic [16:0] floor_bw;
	logic [21:0] add_act, add_sch;
	logic [21:0] m1_umax;
	logic [22:0] num;
	logic [48:0] bw_exec;
	logic [49:0] ur_prod;
	logic [48:0] vt_sum;
	logic [47:0] dt;
	logic [49:0] bud_big;
	logic [48:0] uq_prod;
	logic        in_tab_w;

	assign m_eff    = (proc_count == 5'd0) ? 5'd1 : proc_count;
	assign floor_bw = (min_bw == 17'd0) ? 17'd1 : min_bw;
	assign add_act  = {1'b0, active_q} + {5'd0, u_q};
	assign add_sch  = {1'b0, sched_q} + {5'd0, u_q};
	assign m1_umax  = (m_eff - 5'd1) * umax_q;
	assign num      = {1'b0, m1_umax} + {2'd0, sched_q};
	assign bw_exec  = bw_q * exec_q;
	assign ur_prod  = u_q * drsp.remainder;
	assign vt_sum   = {1'b0, vt_q} + {1'b0, drsp.quotient[47:0]};
	assign dt       = dl_q - vt_q;
	assign uq_prod  = u_q * q_q;
	assign bud_big  = {1'b0, uq_prod} + {1'b0, drsp.quotient[48:0]};
	assign in_tab_w = ({28'd0, server_index} < 32'(MAX_SERVERS));

	assign in_ready = (state_q == S_IDLE) && !out_v_q;

	always_ff @(posedge clk) begin
		rd_data_s1 <= util_mem[scan_idx_q];
		rd_flag_s1 <= flag_q[scan_idx_q];
		if (state_q == S_UPD && op_q == grub_pkg::OP_ACTIVATE && in_tab_q && !flag_q[idx_q])
			util_mem[idx_q] <= u_q;
	end

	always_comb begin
		dreq = '0;
		case (state_q)
			S_BWDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = {41'd0, num};
				dreq.divisor  = {28'd0, m_eff};
			end
			S_ADV: begin
				dreq.start    = 1'b1;
				dreq.dividend = {15'd0, bw_exec};
				dreq.divisor  = {16'd0, u_q};
			end
			S_BUDQ: begin
				dreq.start    = 1'b1;
				dreq.dividend = {16'd0, dt};
				dreq.divisor  = {16'd0, bw_q};
			end
			S_BUDR: begin
				dreq.start    = 1'b1;
				dreq.dividend = {14'd0, ur_prod};
				dreq.divisor  = {16'd0, bw_q};
			end
			default: dreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			flag_q     <= '0;
			sched_q    <= '0;
			active_q   <= '0;
			out_v_q    <= 1'b0;
			scan_idx_q <= '0;
		end else begin
			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q     <= opcode;
						u_q      <= utilization;
						exec_q   <= exec_ticks;
						now_q    <= now_time;
						vt_q     <= server_vtime;
						dl_q     <= deadline;
						in_tab_q <= in_tab_w;
						idx_q    <= IW'(server_index);
						state_q  <= S_UPD;
					end
				end
				S_UPD: begin
					case (op_q)
						grub_pkg::OP_ACTIVATE: begin
							active_q <= add_act[21] ? grub_pkg::SUM_MAX : add_act[20:0];
							if (in_tab_q && !flag_q[idx_q]) begin
								sched_q <= add_sch[21] ? grub_pkg::SUM_MAX : add_sch[20:0];
								flag_q[idx_q] <= 1'b1;
							end
						end
						grub_pkg::OP_COMPLETE, grub_pkg::OP_NONCONTEND:
							active_q <= ({4'd0, u_q} > active_q) ? 21'd0
								: active_q - {4'd0, u_q};
						grub_pkg::OP_DETACH: begin
							if (in_tab_q && flag_q[idx_q]) begin
								sched_q <= ({4'd0, u_q} > sched_q) ? 21'd0
									: sched_q - {4'd0, u_q};
								flag_q[idx_q] <= 1'b0;
							end
						end
						default: ;
					endcase
					scan_idx_q <= '0;
					umax_q     <= '0;
					any_q      <= 1'b0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					// read issued last cycle lands in rd_*_s1 now
					if (scan_idx_q != '0) begin
						if (rd_flag_s1) begin
							any_q <= 1'b1;
							if (rd_data_s1 > umax_q)
								umax_q <= rd_data_s1;
						end
					end
					if (32'(scan_idx_q) == MAX_SERVERS - 1)
						state_q <= S_SCAN_LAST;
					else
						scan_idx_q <= scan_idx_q + IW'(1);
				end
				S_SCAN_LAST: begin
					if (rd_flag_s1) begin
						any_q <= 1'b1;
						if (rd_data_s1 > umax_q)
							umax_q <= rd_data_s1;
					end
					state_q <= S_BWDIV;
				end
				S_BWDIV: state_q <= S_BWWAIT;
				S_BWWAIT: begin
					if (drsp.done) begin
						if (!any_q)
							bw_q <= grub_pkg::ONE_Q16;
						else if (drsp.quotient < {47'd0, floor_bw})
							bw_q <= floor_bw;
						else if (drsp.quotient > {47'd0, grub_pkg::BW_MAX})
							bw_q <= grub_pkg::BW_MAX;
						else
							bw_q <= drsp.quotient[16:0];
						state_q <= S_BWFIN;
					end
				end
				S_BWFIN: begin
					nvt_q <= (op_q == grub_pkg::OP_ADVANCE && u_q == '0)
						? grub_pkg::T48_MAX : '0;
					bud_q <= '0;
					go_q  <= (op_q == grub_pkg::OP_BUDGET) && (vt_q > now_q) && (vt_q < dl_q);
					if (op_q == grub_pkg::OP_ADVANCE)
						state_q <= (u_q == '0) ? S_FIN : S_ADV;
					else if (op_q == grub_pkg::OP_BUDGET)
						// zero utilization gives zero budget
						state_q <= (dl_q > vt_q && u_q != '0) ? S_BUDQ : S_FIN;
					else
						state_q <= S_FIN;
				end
				S_ADV: state_q <= S_ADVWAIT;
				S_ADVWAIT: begin
					if (drsp.done) begin
						nvt_q <= (drsp.quotient[63:48] != '0 || vt_sum[48])
							? grub_pkg::T48_MAX : vt_sum[47:0];
						state_q <= S_FIN;
					end
				end
				S_BUDQ: state_q <= S_BUDQWAIT;
				S_BUDQWAIT: begin
					if (drsp.done) begin
						q_q <= drsp.quotient[31:0];
						// q < 2^48 and u < 2^17: any q of 2^32 or more saturates
						if (drsp.quotient[63:32] != '0) begin
							bud_q   <= grub_pkg::B32_MAX;
							state_q <= S_FIN;
						end else
							state_q <= S_BUDR;
					end
				end
				S_BUDR: state_q <= S_BUDRWAIT;
				S_BUDRWAIT: begin
					if (drsp.done) begin
						bud_q <= (bud_big[49:32] != '0) ? grub_pkg::B32_MAX : bud_big[31:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid          = out_v_q;
	assign new_virtual_time   = nvt_q;
	assign budget             = bud_q;
	assign go_non_contending  = go_q;
	assign bandwidth          = bw_q;
	assign active_utilization = active_q;

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ap_bw_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bandwidth != '0) else $error("zero bandwidth");

endmodule

// File: dv/grub_reclaim_checker.sv
`timescale 1ns / 100ps

module grub_reclaim_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [3:0]  server_index,
	input  logic [16:0] utilization,
	input  logic [31:0] exec_ticks,
	input  logic [47:0] now_time,
	input  logic [47:0] server_vtime,
	input  logic [47:0] deadline,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [47:0] new_virtual_time,
	input  logic [31:0] budget,
	input  logic        go_non_contending,
	input  logic [16:0] bandwidth,
	input  logic [20:0] active_utilization,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);

	typedef struct packed {
		logic [47:0] nvt;
		logic [31:0] bud;
		logic        go;
		logic [16:0] bw;
		logic [20:0] act;
	} reclaim_result_t;

	reclaim_result_t expected_results[$];

	logic [4:0]  proc_count;
	logic [16:0] bw_floor;
	logic        member_flag [16];
	logic [16:0] member_util [16];
	logic [20:0] sched_sum;
	logic [20:0] act_sum;

	function automatic logic [20:0] sum_add(logic [20:0] a, logic [16:0] b);
		logic [21:0] s;
		s = a + b;
		return s > grub_pkg::SUM_MAX ? grub_pkg::SUM_MAX : s[20:0];
	endfunction

	function automatic logic [20:0] sum_sub(logic [20:0] a, logic [16:0] b);
		return b > a ? 21'd0 : a - b;
	endfunction

	function automatic logic [63:0] reclaim_bw();
		logic [63:0] m, umax, bw, fl;
		logic any;
		m = proc_count ? proc_count : 1;
		umax = 0;
		any = 0;
		for (int i = 0; i < 16; i++)
			if (member_flag[i]) begin
				any = 1;
				if (member_util[i] > umax) umax = member_util[i];
			end
		if (!any) return grub_pkg::ONE_Q16;
		bw = ((m - 1) * umax + sched_sum) / m;
		fl = bw_floor ? bw_floor : 1;
		if (bw < fl) bw = fl;
		return bw > grub_pkg::BW_MAX ? grub_pkg::BW_MAX : bw;
	endfunction

	task automatic apply_event(output reclaim_result_t r);
		logic [63:0] bw, inc, dt, q, rem, t;
		r = '0;
		case (opcode)
			grub_pkg::OP_ACTIVATE: begin
				act_sum = sum_add(act_sum, utilization);
				if (!member_flag[server_index]) begin
					sched_sum = sum_add(sched_sum, utilization);
					member_util[server_index] = utilization;
					member_flag[server_index] = 1;
				end
			end
			grub_pkg::OP_COMPLETE, grub_pkg::OP_NONCONTEND:
				act_sum = sum_sub(act_sum, utilization);
			grub_pkg::OP_DETACH:
				if (member_flag[server_index]) begin
					sched_sum = sum_sub(sched_sum, utilization);
					member_flag[server_index] = 0;
				end
			default: ;
		endcase
		bw = reclaim_bw();
		if (opcode == grub_pkg::OP_ADVANCE) begin
			if (utilization == 0) r.nvt = grub_pkg::T48_MAX;
			else begin
				inc = (bw * exec_ticks) / utilization;
				r.nvt = (inc > grub_pkg::T48_MAX - server_vtime) ? grub_pkg::T48_MAX
					: 48'(server_vtime + inc);
			end
		end else if (opcode == grub_pkg::OP_BUDGET) begin
			if (deadline > server_vtime) begin
				dt = deadline - server_vtime;
				q = dt / bw;
				rem = dt % bw;
				if (utilization != 0 && q > grub_pkg::B32_MAX / utilization)
					r.bud = grub_pkg::B32_MAX;
				else begin
					t = utilization * q + (utilization * rem) / bw;
					r.bud = t > grub_pkg::B32_MAX ? grub_pkg::B32_MAX : t[31:0];
				end
			end
			r.go = server_vtime > now_time && server_vtime < deadline;
		end
		r.bw = bw[16:0];
		r.act = act_sum;
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", result_count, field, got,
			want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reclaim_result_t r;
		if (!arst_n) begin
			proc_count = 1;
			bw_floor = 655;
			sched_sum = 0;
			act_sum = 0;
			for (int i = 0; i < 16; i++) begin
				member_flag[i] = 0;
				member_util[i] = 0;
			end
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == grub_pkg::REG_PROC_COUNT) proc_count = pwdata[4:0];
				else bw_floor = pwdata[16:0];
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected output transfer", 1, 0);
				end else begin
					r = expected_results.pop_front();
					if (new_virtual_time !== r.nvt)
						report_mismatch("new_virtual_time", new_virtual_time, r.nvt);
					if (budget !== r.bud) report_mismatch("budget", budget, r.bud);
					if (go_non_contending !== r.go)
						report_mismatch("go_non_contending", go_non_contending, r.go);
					if (bandwidth !== r.bw) report_mismatch("bandwidth", bandwidth, r.bw);
					if (active_utilization !== r.act)
						report_mismatch("active_utilization", active_utilization, r.act);
				end
				result_count++;
			end
			if (in_valid && in_ready) begin
				apply_event(r);
				expected_results.push_back(r);
			end
			pending_count = expected_results.size();
		end
	end
endmodule

// File: dv/grub_bandwidth_reclaim_unit_core_test.sv
`timescale 1ns / 100ps

module grub_bandwidth_reclaim_unit_core_test;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [2:0] ADDR_PROC_COUNT = 3'd0;
	localparam logic [2:0] ADDR_MIN_BW     = 3'd4;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0, in_ready;
	logic [2:0]  opcode = 0;
	logic [3:0]  server_index = 0;
	logic [16:0] utilization = 0;
	logic [31:0] exec_ticks = 0;
	logic [47:0] now_time = 0, server_vtime = 0, deadline = 0;
	logic        out_valid, out_ready = 0;
	logic [47:0] new_virtual_time;
	logic [31:0] budget;
	logic        go_non_contending;
	logic [16:0] bandwidth;
	logic [20:0] active_utilization;
	int          fail_count, pending_count, result_count;
	int          cycle_count = 0;
	logic        drain_stall = 1;
	logic [16:0] held_util [16];
	logic        held [16];

	localparam int CYCLE_LIMIT = 2000000;

	always #10 clk = ~clk;

	grub_bandwidth_reclaim_unit_core dut (.*);

	grub_reclaim_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall before each transfer
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (drain_stall) begin
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
				if (gap > 0) begin
					out_ready <= 0;
					repeat (gap) @(negedge clk);
				end
				out_ready <= 1;
				do @(posedge clk); while (!out_valid);
			end else out_ready <= 1;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic wait_drained();
		while (pending_count != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic send_event(logic [2:0] op, logic [3:0] idx, logic [16:0] u,
		logic [31:0] ex, logic [47:0] nw, logic [47:0] vt, logic [47:0] dl, bit pace);
		if (pace) repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17))
			@(negedge clk);
		@(negedge clk);
		in_valid <= 1; opcode <= op; server_index <= idx; utilization <= u;
		exec_ticks <= ex; now_time <= nw; server_vtime <= vt; deadline <= dl;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 0;
		if (op == grub_pkg::OP_ACTIVATE && !held[idx]) begin
			held[idx] = 1; held_util[idx] = u;
		end else if (op == grub_pkg::OP_DETACH) held[idx] = 0;
	endtask

	function automatic logic [47:0] rand48();
		case ($urandom_range(0, 3))
			0: return 48'({$urandom, $urandom});
			1: return 48'($urandom_range(0, 1000));
			2: return grub_pkg::T48_MAX - 48'($urandom_range(0, 1000));
			default: return {16'h0, $urandom};
		endcase
	endfunction

	function automatic logic [16:0] rand_util();
		case ($urandom_range(0, 4))
			0: return 17'($urandom_range(0, 3));
			1: return 17'(32'd65536 - $urandom_range(0, 3));
			2: return 17'({$urandom_range(0, 1), 16'h0} | $urandom_range(0, 65535));
			default: return 17'($urandom_range(1, 65536));
		endcase
	endfunction

	task automatic random_event();
		logic [3:0]  idx;
		logic [2:0]  op;
		logic [16:0] u;
		logic [47:0] vt;
		idx = 4'($urandom_range(0, 15));
		op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
		u = rand_util();
		// mostly pair detach and complete with the stored utilization
		if (held[idx] && op inside {grub_pkg::OP_COMPLETE, grub_pkg::OP_DETACH}
			&& $urandom_range(0, 3) != 0)
			u = held_util[idx];
		vt = rand48();
		send_event(op, idx, u, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000),
			rand48(), vt,
			$urandom_range(0, 1) ? vt + 48'($urandom_range(0, 100000)) : rand48(), 1);
	endtask

	initial begin
		int n = 0;
		for (int i = 0; i < 16; i++) held[i] = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		// directed: extremes and each special case
		send_event(grub_pkg::OP_ADVANCE, 0, 17'd100, 32'hFFFFFFFF, 0, 48'd5, 0, 0);
		send_event(grub_pkg::OP_ACTIVATE, 0, 17'd65536, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_ACTIVATE, 0, 17'd1000, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_ACTIVATE, 15, 17'd1, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_ADVANCE, 15, 17'd0, 32'd10, 0, 48'd7, 0, 0);
		send_event(grub_pkg::OP_ADVANCE, 15, 17'd1, 32'hFFFFFFFF, 0,
			grub_pkg::T48_MAX - 48'd3, 0, 0);
		send_event(grub_pkg::OP_BUDGET, 0, 17'd65536, 0, 48'd1, 48'd2, grub_pkg::T48_MAX, 0);
		send_event(grub_pkg::OP_BUDGET, 0, 17'd0, 0, 48'd5, 48'd5, 48'd5, 0);
		send_event(grub_pkg::OP_BUDGET, 0, 17'd1, 0, grub_pkg::T48_MAX, 48'd100, 48'd50, 0);
		send_event(grub_pkg::OP_BUDGET, 0, 17'h1FFFF, 0, 0, 0, 48'd1234567, 0);
		send_event(grub_pkg::OP_COMPLETE, 0, 17'h1FFFF, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_NONCONTEND, 0, 17'd1, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_DETACH, 7, 17'd5, 0, 0, 0, 0, 0);
		send_event(grub_pkg::OP_DETACH, 0, 17'h1FFFF, 0, 0, 0, 0, 0);
		send_event(OP_SPARE_A, 3, 17'd9, 32'd9, 48'd9, 48'd9, 48'd9, 0);
		send_event(OP_SPARE_B, 3, 17'd9, 32'd9, 48'd9, 48'd9, 48'd9, 0);
		for (int i = 0; i < 8; i++)
			send_event(grub_pkg::OP_ACTIVATE, 4'(i), 17'h1FFFF, 0, 0, 0, 0, 0);
		// sender hold-off until everything is back
		wait_drained();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(ADDR_PROC_COUNT, 32'd16); write_reg(ADDR_MIN_BW, 32'd1); end
				1: begin write_reg(ADDR_PROC_COUNT, 32'd0); write_reg(ADDR_MIN_BW, 32'd0); end
				2: begin
					write_reg(ADDR_PROC_COUNT, 32'd4);
					write_reg(ADDR_MIN_BW, 32'd65536);
				end
				3: begin
					write_reg(ADDR_PROC_COUNT, 32'd31);
					write_reg(ADDR_MIN_BW, 32'h1FFFF);
				end
				4: begin write_reg(ADDR_PROC_COUNT, 32'd2); write_reg(ADDR_MIN_BW, 32'd655); end
				default: begin
					write_reg(ADDR_PROC_COUNT, $urandom_range(1, 16));
					write_reg(ADDR_MIN_BW, $urandom_range(1, 65536));
				end
			endcase
			for (int k = 0; k < 325; k++) begin
				random_event();
				n++;
			end
			wait_drained();
		end
		drain_stall = 0;
		$display("Covered %0d directed and %0d random events, %0d results checked,", 24, n,
			result_count);
		$display("across six register settings including m = 0, 16, 31 and floor extremes.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: grub_bandwidth_reclaim_unit_core.f
sv/grub_pkg.sv
sv/grub_div.sv
sv/grub_core_ctl.sv
sv/grub_bandwidth_reclaim_unit_core.sv
dv/grub_reclaim_checker.sv
dv/grub_bandwidth_reclaim_unit_core_test.sv
